// File: design/psn_pkg.sv
// shared widths, types and codes of the point to segment nearest block
`timescale 1ns / 1ps
`default_nettype none
package psn_pkg;

	localparam int COORD_W  = 32;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int LEN2_W   = PROD_W;
	localparam int HALF_W   = LEN2_W / 2;
	localparam int QUO_W    = DIFF_W + 1;
	localparam int NUM_W    = QUO_W + LEN2_W;
	localparam int ROOT_W   = 34;
	localparam int SQ_W     = 2 * ROOT_W;
	localparam int DIST_W   = 33;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	typedef enum logic [1:0] {
		REG_INTERIOR = 2'd0,
		REG_START    = 2'd1,
		REG_END      = 2'd2,
		REG_ZERO     = 2'd3
	} region_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_X = 3'd0,
		CFG_START_Y = 3'd1,
		CFG_END_X   = 3'd2,
		CFG_END_Y   = 3'd3
	} cfg_reg_t;

	// sideband that rides alongside the dividers
	typedef struct packed {
		coord_t  px;
		coord_t  py;
		logic    neg_dx;
		logic    neg_dy;
		region_t region;
	} div_sb_t;

	// sideband that rides alongside the root
	typedef struct packed {
		coord_t  nx;
		coord_t  ny;
		region_t region;
	} root_sb_t;

endpackage
`default_nettype wire

// File: design/psn_point_if.sv
// query point channel
`timescale 1ns / 1ps
`default_nettype none
interface psn_point_if import psn_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink (input valid, input point_x, input point_y, output ready);
endinterface
`default_nettype wire

// File: design/psn_result_if.sv
// nearest point result channel
`timescale 1ns / 1ps
`default_nettype none
interface psn_result_if import psn_pkg::*; ();
	logic              valid;
	logic              ready;
	coord_t            nearest_x;
	coord_t            nearest_y;
	logic [DIST_W-1:0] distance;
	logic [1:0]        region;

	modport source (output valid, output nearest_x, output nearest_y, output distance,
		output region, input ready);
	modport sink (input valid, input nearest_x, input nearest_y, input distance,
		input region, output ready);
endinterface
`default_nettype wire

// File: design/psn_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module psn_div import psn_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [LEN2_W-1:0] den,
	output logic [QUO_W-1:0]  quo
);
	logic [LEN2_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0]  low_s [QUO_W];
	logic [QUO_W-1:0]  quo_s [QUO_W];
	logic [LEN2_W-1:0] den_s [QUO_W];

	logic [LEN2_W-1:0] rem_nx [QUO_W];
	logic [QUO_W-1:0]  low_nx [QUO_W];
	logic [QUO_W-1:0]  quo_nx [QUO_W];

	logic [LEN2_W-1:0] rin;
	logic [QUO_W-1:0]  lin;
	logic [QUO_W-1:0]  qin;
	logic [LEN2_W-1:0] din;
	logic [LEN2_W:0]   trial;
	logic [LEN2_W:0]   diff;
	logic              take;

	always_comb begin
		for (int i = 0; i < QUO_W; i++) begin
			if (i == 0) begin
				rin = num[NUM_W-1:QUO_W];
				lin = num[QUO_W-1:0];
				qin = '0;
				din = den;
			end else begin
				rin = rem_s[i-1];
				lin = low_s[i-1];
				qin = quo_s[i-1];
				din = den_s[i-1];
			end
			trial = {rin, lin[QUO_W-1]};
			take  = trial >= {1'b0, din};
			diff  = trial - {1'b0, din};
			rem_nx[i] = take ? diff[LEN2_W-1:0] : trial[LEN2_W-1:0];
			low_nx[i] = {lin[QUO_W-2:0], 1'b0};
			quo_nx[i] = {qin[QUO_W-2:0], take};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QUO_W; i++) begin
				rem_s[i] <= rem_nx[i];
				low_s[i] <= low_nx[i];
				quo_s[i] <= quo_nx[i];
				den_s[i] <= (i == 0) ? den : den_s[(i == 0) ? 0 : i - 1];
			end
		end
	end

	assign quo = quo_s[QUO_W-1];
endmodule
`default_nettype wire

// File: design/psn_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module psn_sqrt import psn_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [SQ_W-1:0]   sq,
	output logic [ROOT_W-1:0] root
);
	localparam int REM_W = ROOT_W + 3;

	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [SQ_W-1:0]   src_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];

	logic [REM_W-1:0]  rem_nx  [ROOT_W];
	logic [SQ_W-1:0]   src_nx  [ROOT_W];
	logic [ROOT_W-1:0] root_nx [ROOT_W];

	logic [REM_W-1:0]  rin;
	logic [SQ_W-1:0]   sin;
	logic [ROOT_W-1:0] oin;
	logic [REM_W-1:0]  shifted;
	logic [REM_W-1:0]  trial;
	logic              take;

	always_comb begin
		for (int i = 0; i < ROOT_W; i++) begin
			if (i == 0) begin
				rin = '0;
				sin = sq;
				oin = '0;
			end else begin
				rin = rem_s[i-1];
				sin = src_s[i-1];
				oin = root_s[i-1];
			end
			shifted = {rin[REM_W-3:0], sin[SQ_W-1:SQ_W-2]};
			trial   = {1'b0, oin, 2'b01};
			take    = shifted >= trial;
			rem_nx[i]  = take ? shifted - trial : shifted;
			src_nx[i]  = {sin[SQ_W-3:0], 2'b00};
			root_nx[i] = {oin[ROOT_W-2:0], take};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < ROOT_W; i++) begin
				rem_s[i]  <= rem_nx[i];
				src_s[i]  <= src_nx[i];
				root_s[i] <= root_nx[i];
			end
		end
	end

	assign root = root_s[ROOT_W-1];
endmodule
`default_nettype wire

// File: design/point_segment_nearest.sv
// point to segment nearest point and distance, top level
// a query advances one stage per cycle from query transaction to result while the pipe moves
// throughput: one query per cycle; the whole pipe holds while a result waits unreleased
// depth is set by the two 34-stage bit-serial units (projection divide and distance root)
// reset clears every stage valid bit and the four segment registers to zero
`timescale 1ns / 1ps
`default_nettype none
module point_segment_nearest import psn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	psn_point_if.sink            query,
	psn_result_if.source         result
);
	localparam int FRONT_N  = 6;
	localparam int BACK_N   = 4;
	localparam int PIPE_LEN = FRONT_N + QUO_W + BACK_N + ROOT_W;
	localparam int DIV_OUT  = FRONT_N + QUO_W - 1;

	// segment registers
	coord_t start_x_q, start_y_q, end_x_q, end_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				CFG_START_X: start_x_q <= cfg_data;
				CFG_START_Y: start_y_q <= cfg_data;
				CFG_END_X:   end_x_q   <= cfg_data;
				CFG_END_Y:   end_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: the pipe moves unless a result sits unclaimed at the end
	logic en;
	logic vld_s [PIPE_LEN];

	assign en          = !vld_s[PIPE_LEN-1] || result.ready;
	assign query.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LEN; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= query.valid;
			for (int i = 1; i < PIPE_LEN; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// s1: differences against the segment start
	coord_t px_s1, py_s1;
	diff_t  dx_s1, dy_s1, vx_s1, vy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= query.point_x;
			py_s1 <= query.point_y;
			dx_s1 <= diff_t'(end_x_q) - diff_t'(start_x_q);
			dy_s1 <= diff_t'(end_y_q) - diff_t'(start_y_q);
			vx_s1 <= diff_t'(query.point_x) - diff_t'(start_x_q);
			vy_s1 <= diff_t'(query.point_y) - diff_t'(start_y_q);
		end
	end

	// s2: the four dot products terms
	coord_t px_s2, py_s2;
	diff_t  dx_s2, dy_s2;
	prod_t  dxx_s2, dyy_s2, vdx_s2, vdy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dxx_s2 <= dx_s1 * dx_s1;
			dyy_s2 <= dy_s1 * dy_s1;
			vdx_s2 <= vx_s1 * dx_s1;
			vdy_s2 <= vy_s1 * dy_s1;
		end
	end

	// s3: squared length and projection dot, both exact
	coord_t            px_s3, py_s3;
	diff_t             dx_s3, dy_s3;
	logic [LEN2_W-1:0] len2_s3;
	prod_t             dot_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s3   <= px_s2;
			py_s3   <= py_s2;
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			len2_s3 <= $unsigned(dxx_s2 + dyy_s2);
			dot_s3  <= vdx_s2 + vdy_s2;
		end
	end

	// s4: region decision and axis magnitudes
	region_t           region_d;
	coord_t            px_s4, py_s4;
	logic              neg_dx_s4, neg_dy_s4;
	logic [DIFF_W-1:0] adx_s4, ady_s4;
	logic [LEN2_W-1:0] len2_s4, dot_s4;
	region_t           region_s4;

	always_comb begin
		if (len2_s3 == '0) begin
			region_d = REG_ZERO;
		end else if (dot_s3 < 0) begin
			region_d = REG_START;
		end else if ($unsigned(dot_s3) > len2_s3) begin
			region_d = REG_END;
		end else begin
			region_d = REG_INTERIOR;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s4     <= px_s3;
			py_s4     <= py_s3;
			neg_dx_s4 <= dx_s3[DIFF_W-1];
			neg_dy_s4 <= dy_s3[DIFF_W-1];
			adx_s4    <= dx_s3[DIFF_W-1] ? $unsigned(-dx_s3) : $unsigned(dx_s3);
			ady_s4    <= dy_s3[DIFF_W-1] ? $unsigned(-dy_s3) : $unsigned(dy_s3);
			len2_s4   <= len2_s3;
			dot_s4    <= $unsigned(dot_s3);
			region_s4 <= region_d;
		end
	end

	// s5: numerator partial products, dot split into two halves
	div_sb_t           sb_s5;
	logic [LEN2_W-1:0] len2_s5;
	logic [PROD_W-1:0] xlo_s5, xhi_s5, ylo_s5, yhi_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s5   <= '{px: px_s4, py: py_s4, neg_dx: neg_dx_s4, neg_dy: neg_dy_s4,
				region: region_s4};
			len2_s5 <= len2_s4;
			xlo_s5  <= dot_s4[HALF_W-1:0] * adx_s4;
			xhi_s5  <= dot_s4[LEN2_W-1:HALF_W] * adx_s4;
			ylo_s5  <= dot_s4[HALF_W-1:0] * ady_s4;
			yhi_s5  <= dot_s4[LEN2_W-1:HALF_W] * ady_s4;
		end
	end

	// s6: full numerators
	div_sb_t           sb_s6;
	logic [LEN2_W-1:0] len2_s6;
	logic [NUM_W-1:0]  numx_s6, numy_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s6   <= sb_s5;
			len2_s6 <= len2_s5;
			numx_s6 <= (NUM_W'(xhi_s5) << HALF_W) + NUM_W'(xlo_s5);
			numy_s6 <= (NUM_W'(yhi_s5) << HALF_W) + NUM_W'(ylo_s5);
		end
	end

	// projection divides, one per axis
	logic [QUO_W-1:0] qx, qy;

	psn_div u_div_x (.clk(clk), .en(en), .num(numx_s6), .den(len2_s6), .quo(qx));
	psn_div u_div_y (.clk(clk), .en(en), .num(numy_s6), .den(len2_s6), .quo(qy));

	div_sb_t dsb_s [QUO_W];

	always_ff @(posedge clk) begin
		if (en) begin
			dsb_s[0] <= sb_s6;
			for (int i = 1; i < QUO_W; i++) dsb_s[i] <= dsb_s[i-1];
		end
	end

	// s7: nearest point from region and quotient
	div_sb_t                  dsb_out;
	logic signed [QUO_W:0]    offx, offy;
	logic signed [QUO_W:0]    sumx, sumy;
	coord_t                   nx_d, ny_d;
	coord_t                   px_s7, py_s7, nx_s7, ny_s7;
	region_t                  region_s7;

	assign dsb_out = dsb_s[QUO_W-1];

	always_comb begin
		offx = dsb_out.neg_dx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
		offy = dsb_out.neg_dy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
		sumx = (QUO_W+1)'(start_x_q) + offx;
		sumy = (QUO_W+1)'(start_y_q) + offy;
		case (dsb_out.region)
			REG_INTERIOR: begin
				nx_d = sumx[COORD_W-1:0];
				ny_d = sumy[COORD_W-1:0];
			end
			REG_END: begin
				nx_d = end_x_q;
				ny_d = end_y_q;
			end
			default: begin
				nx_d = start_x_q;
				ny_d = start_y_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s7     <= dsb_out.px;
			py_s7     <= dsb_out.py;
			nx_s7     <= nx_d;
			ny_s7     <= ny_d;
			region_s7 <= dsb_out.region;
		end
	end

	// s8: error vector
	root_sb_t sb_s8;
	diff_t    ex_s8, ey_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s8 <= '{nx: nx_s7, ny: ny_s7, region: region_s7};
			ex_s8 <= diff_t'(px_s7) - diff_t'(nx_s7);
			ey_s8 <= diff_t'(py_s7) - diff_t'(ny_s7);
		end
	end

	// s9: squares of the error
	root_sb_t sb_s9;
	prod_t    exx_s9, eyy_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s9  <= sb_s8;
			exx_s9 <= ex_s8 * ex_s8;
			eyy_s9 <= ey_s8 * ey_s8;
		end
	end

	// s10: squared distance
	root_sb_t        sb_s10;
	logic [SQ_W-1:0] sq_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s10 <= sb_s9;
			sq_s10 <= SQ_W'($unsigned(exx_s9)) + SQ_W'($unsigned(eyy_s9));
		end
	end

	// distance root; its last stage is the output register
	logic [ROOT_W-1:0] root;

	psn_sqrt u_sqrt (.clk(clk), .en(en), .sq(sq_s10), .root(root));

	root_sb_t rsb_s [ROOT_W];

	always_ff @(posedge clk) begin
		if (en) begin
			rsb_s[0] <= sb_s10;
			for (int i = 1; i < ROOT_W; i++) rsb_s[i] <= rsb_s[i-1];
		end
	end

	assign result.valid     = vld_s[PIPE_LEN-1];
	assign result.nearest_x = rsb_s[ROOT_W-1].nx;
	assign result.nearest_y = rsb_s[ROOT_W-1].ny;
	assign result.region    = rsb_s[ROOT_W-1].region;
	assign result.distance  = root[DIST_W-1:0];

	// an accepted query lands in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		query.valid && query.ready |=> vld_s[0])
		else $error("accepted query missing from first stage");

	// interior projections never exceed the segment
	a_interior_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[3] && region_s4 == REG_INTERIOR |-> dot_s4 <= len2_s4 && len2_s4 != '0)
		else $error("interior projection out of range");

	// a negative dot on a real segment clamps to the start point
	a_start_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[2] && dot_s3 < 0 && len2_s3 != '0 |=> region_s4 == REG_START)
		else $error("negative projection not clamped to start");

	// the s7 choice of the divider sideband lines up with the valid chain
	a_div_align: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[DIV_OUT] && dsb_out.region == REG_END |=> nx_s7 == end_x_q)
		else $error("end clamp not applied");
endmodule
`default_nettype wire
